// File: rtl/mlfd_pkg.sv
package mlfd_pkg;

	localparam int unsigned TIME_TAG_BYTES = 6;
	localparam int unsigned PASSWORD_BYTES = 16;
	localparam int unsigned LEN_LIMIT      = 4096;

	localparam int unsigned IDX_W = 13;
	localparam int unsigned LEN_W = 16;
	localparam int unsigned TAG_W = IDX_W + 1;

	localparam logic [7:0] START_MARK    = 8'h68;
	localparam logic [7:0] END_MARK      = 8'h16;
	localparam logic [7:0] FC_PASSWORD_A = 8'h04;
	localparam logic [7:0] FC_PASSWORD_B = 8'h05;

	localparam logic [IDX_W-1:0] HEADER_LEN   = IDX_W'(10);
	localparam logic [LEN_W-1:0] LEN_LIMIT_V  = LEN_W'(LEN_LIMIT);
	localparam logic [TAG_W-1:0] TT_SPAN      = TAG_W'(TIME_TAG_BYTES);
	localparam logic [TAG_W-1:0] PW_SPAN      = TAG_W'(PASSWORD_BYTES);

	localparam logic [23:0] ADDR_BROADCAST = 24'hFFFFFF;

	typedef enum logic [3:0] {
		PH_HUNT   = 4'd0,
		PH_L1LO   = 4'd1,
		PH_L1HI   = 4'd2,
		PH_L2LO   = 4'd3,
		PH_L2HI   = 4'd4,
		PH_START2 = 4'd5,
		PH_BODY   = 4'd6,
		PH_CSUM   = 4'd7,
		PH_END    = 4'd8
	} phase_t;

	typedef enum logic [1:0] {
		KIND_DATA     = 2'd0,
		KIND_PASSWORD = 2'd1,
		KIND_TIME_TAG = 2'd2,
		KIND_VERDICT  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_GOOD = 2'd0,
		ST_CSUM = 2'd1,
		ST_END  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CFG_MAX_LEN   = 2'd0,
		CFG_OWN_AREA  = 2'd1,
		CFG_OWN_TERM  = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data_byte;
		logic [7:0]  control;
		logic [7:0]  master_addr;
		logic [7:0]  function_code;
		logic [7:0]  sequence_res;
		logic [23:0] area_code;
		logic [23:0] terminal_addr;
		logic        addr_match;
		logic [1:0]  status;
		logic        last;
	} result_t;

endpackage

// File: rtl/meter_link_frame_deframer_core.sv
// a result is registered at the transaction of the byte that causes it and is valid in the next cycle
// throughput: one byte per cycle unless a held result is stalled, set by the single result register
// ready drops only while a held result is stalled by the consumer
// reset: asynchronous, returns to hunting for the first start byte with no result pending
// reset also restores max_frame_len to 4096 and both own addresses to zero
module meter_link_frame_deframer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  data_byte,
	output logic [7:0]  control,
	output logic [7:0]  master_addr,
	output logic [7:0]  function_code,
	output logic [7:0]  sequence_res,
	output logic [23:0] area_code,
	output logic [23:0] terminal_addr,
	output logic        addr_match,
	output logic [1:0]  status,
	output logic        last
);
	import mlfd_pkg::*;

	logic [12:0] max_frame_len_q;
	logic [23:0] own_area_q;
	logic [23:0] own_term_q;

	phase_t      phase_q, phase_d;
	logic [IDX_W-1:0] byte_index_q, byte_index_d;
	logic [LEN_W-1:0] length_first_q, length_first_d;
	logic [LEN_W-1:0] length_second_q, length_second_d;
	logic [7:0]  running_sum_q, running_sum_d;
	logic [7:0]  held_control_q, held_control_d;
	logic [23:0] held_area_q, held_area_d;
	logic [23:0] held_terminal_q, held_terminal_d;
	logic [7:0]  held_master_q, held_master_d;
	logic [7:0]  held_function_q, held_function_d;
	logic [7:0]  held_sequence_q, held_sequence_d;
	logic        checksum_ok_q, checksum_ok_d;

	logic        out_valid_q;
	result_t     res_q, res_d;
	logic        res_emit;
	logic        accept;

	logic [LEN_W-1:0] limit;
	logic [IDX_W-1:0] index_next;
	logic [TAG_W-1:0] tag_d, tag_n, tt_add, pw_add;
	logic        pw_on;
	logic [1:0]  tag_kind;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_len_q <= 13'(LEN_LIMIT);
			own_area_q      <= '0;
			own_term_q      <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_LEN:  max_frame_len_q <= cfg_data[12:0];
				CFG_OWN_AREA: own_area_q      <= cfg_data;
				CFG_OWN_TERM: own_term_q      <= cfg_data;
				default:      ;
			endcase
		end
	end

	assign limit = ({3'b000, max_frame_len_q} > LEN_LIMIT_V) ? LEN_LIMIT_V
	             : {3'b000, max_frame_len_q};
	assign index_next = byte_index_q + IDX_W'(1);

	// data byte classification
	assign pw_on  = (held_function_q == FC_PASSWORD_A) || (held_function_q == FC_PASSWORD_B);
	assign tag_d  = {1'b0, byte_index_q - HEADER_LEN};
	assign tag_n  = {1'b0, length_first_q[IDX_W-1:0] - HEADER_LEN};
	assign tt_add = tag_d + (held_sequence_q[7] ? TT_SPAN : '0);
	assign pw_add = tt_add + (pw_on ? PW_SPAN : '0);

	always_comb begin
		if (tt_add >= tag_n) begin
			tag_kind = KIND_TIME_TAG;
		end else if (pw_add >= tag_n) begin
			tag_kind = KIND_PASSWORD;
		end else begin
			tag_kind = KIND_DATA;
		end
	end

	// next state
	always_comb begin
		phase_d         = phase_q;
		byte_index_d    = byte_index_q;
		length_first_d  = length_first_q;
		length_second_d = length_second_q;
		running_sum_d   = running_sum_q;
		held_control_d  = held_control_q;
		held_area_d     = held_area_q;
		held_terminal_d = held_terminal_q;
		held_master_d   = held_master_q;
		held_function_d = held_function_q;
		held_sequence_d = held_sequence_q;
		checksum_ok_d   = checksum_ok_q;
		case (phase_q)
			PH_HUNT: begin
				if (rx_byte == START_MARK) begin
					phase_d = PH_L1LO;
				end
			end
			PH_L1LO: begin
				length_first_d = {8'h00, rx_byte};
				phase_d = PH_L1HI;
			end
			PH_L1HI: begin
				length_first_d = {rx_byte, length_first_q[7:0]};
				phase_d = PH_L2LO;
			end
			PH_L2LO: begin
				length_second_d = {8'h00, rx_byte};
				phase_d = PH_L2HI;
			end
			PH_L2HI: begin
				length_second_d = {rx_byte, length_second_q[7:0]};
				phase_d = PH_START2;
			end
			PH_START2: begin
				if (rx_byte != START_MARK || length_first_q != length_second_q ||
				    length_first_q > limit ||
				    length_first_q < {3'b000, HEADER_LEN}) begin
					phase_d = PH_HUNT;
				end else begin
					byte_index_d  = '0;
					running_sum_d = '0;
					phase_d = PH_BODY;
				end
			end
			PH_BODY: begin
				running_sum_d = running_sum_q + rx_byte;
				byte_index_d  = index_next;
				if ({3'b000, index_next} >= length_first_q || index_next == '0) begin
					phase_d = PH_CSUM;
				end
				case (byte_index_q)
					IDX_W'(0): held_control_d          = rx_byte;
					IDX_W'(1): held_area_d[7:0]        = rx_byte;
					IDX_W'(2): held_area_d[15:8]       = rx_byte;
					IDX_W'(3): held_area_d[23:16]      = rx_byte;
					IDX_W'(4): held_terminal_d[7:0]    = rx_byte;
					IDX_W'(5): held_terminal_d[15:8]   = rx_byte;
					IDX_W'(6): held_terminal_d[23:16]  = rx_byte;
					IDX_W'(7): held_master_d           = rx_byte;
					IDX_W'(8): held_function_d         = rx_byte;
					IDX_W'(9): held_sequence_d         = rx_byte;
					default:   ;
				endcase
			end
			PH_CSUM: begin
				checksum_ok_d = (rx_byte == running_sum_q);
				phase_d = PH_END;
			end
			PH_END: begin
				phase_d = PH_HUNT;
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	// result item
	always_comb begin
		res_d    = '0;
		res_emit = 1'b0;
		case (phase_q)
			PH_BODY: begin
				if (byte_index_q >= HEADER_LEN) begin
					res_emit       = 1'b1;
					res_d.kind      = tag_kind;
					res_d.data_byte = rx_byte;
				end
			end
			PH_END: begin
				res_emit            = 1'b1;
				res_d.kind          = KIND_VERDICT;
				res_d.control       = held_control_q;
				res_d.master_addr   = held_master_q;
				res_d.function_code = held_function_q;
				res_d.sequence_res  = held_sequence_q;
				res_d.area_code     = held_area_q;
				res_d.terminal_addr = held_terminal_q;
				res_d.addr_match    = (held_area_q == ADDR_BROADCAST &&
				                       held_terminal_q == ADDR_BROADCAST) ||
				                      (held_area_q == own_area_q &&
				                       held_terminal_q == own_term_q);
				if (!checksum_ok_q) begin
					res_d.status = ST_CSUM;
				end else if (rx_byte != END_MARK) begin
					res_d.status = ST_END;
				end else begin
					res_d.status = ST_GOOD;
				end
				res_d.last = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			byte_index_q <= '0;
			length_first_q <= '0;
			length_second_q <= '0;
			running_sum_q <= '0;
			checksum_ok_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q         <= phase_d;
				byte_index_q    <= byte_index_d;
				length_first_q  <= length_first_d;
				length_second_q <= length_second_d;
				running_sum_q   <= running_sum_d;
				checksum_ok_q   <= checksum_ok_d;
			end
			if (accept && res_emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_control_q  <= '0;
			held_area_q     <= '0;
			held_terminal_q <= '0;
			held_master_q   <= '0;
			held_function_q <= '0;
			held_sequence_q <= '0;
		end else if (accept) begin
			held_control_q  <= held_control_d;
			held_area_q     <= held_area_d;
			held_terminal_q <= held_terminal_d;
			held_master_q   <= held_master_d;
			held_function_q <= held_function_d;
			held_sequence_q <= held_sequence_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res_emit) begin
			res_q <= res_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = res_q.kind;
	assign data_byte     = res_q.data_byte;
	assign control       = res_q.control;
	assign master_addr   = res_q.master_addr;
	assign function_code = res_q.function_code;
	assign sequence_res  = res_q.sequence_res;
	assign area_code     = res_q.area_code;
	assign terminal_addr = res_q.terminal_addr;
	assign addr_match    = res_q.addr_match;
	assign status        = res_q.status;
	assign last          = res_q.last;

	a_verdict_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((res_q.kind == KIND_VERDICT) == res_q.last))
		else $error("last flag disagrees with verdict kind");

	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.kind != KIND_VERDICT |->
		res_q.status == ST_GOOD && !res_q.addr_match && res_q.area_code == '0)
		else $error("data transaction carries verdict fields");

	a_end_gives_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		accept && phase_q == PH_END |=> out_valid_q && res_q.kind == KIND_VERDICT &&
		phase_q == PH_HUNT)
		else $error("end mark position did not yield a verdict");

	a_body_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> {3'b000, byte_index_q} < length_first_q)
		else $error("body index ran past frame length");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> res_q.status != 2'd3)
		else $error("undefined status code");

endmodule
